[rtl/stereo_lookahead_peak_limiter_core_assert.svh]
// assertion helpers for the limiter core
`ifndef STEREO_LOOKAHEAD_PEAK_LIMITER_CORE_ASSERT_SVH
`define STEREO_LOOKAHEAD_PEAK_LIMITER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SLPL_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SLPL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLPL_ASSERT(label, clk, rstn, prop, msg)
`define SLPL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

[rtl/slpl_pkg.sv]
package slpl_pkg;

    localparam int DEFAULT_DELAY_DEPTH = 256;
    localparam int DEFAULT_SAMPLE_BITS = 24;

    localparam int CEIL_W  = 24;
    localparam int COEF_W  = 23;
    localparam int LA_W    = 8;
    localparam int METER_W = 24;
    localparam int CFG_W   = 24;
    localparam int CFG_AW  = 3;

    localparam logic [CFG_AW-1:0] REG_CEILING   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_LIMITER   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ATTACK    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_RELEASE   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_LOOKAHEAD = 3'd4;

    localparam logic [CEIL_W-1:0] CEILING_RST   = 24'd8388608;
    localparam logic [COEF_W-1:0] ATTACK_RST    = 23'd8301680;
    localparam logic [COEF_W-1:0] RELEASE_RST   = 23'd8387152;
    localparam logic [LA_W-1:0]   LOOKAHEAD_RST = 8'd96;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[rtl/slpl_ram.sv]
module slpl_ram #(
    parameter int WIDTH = 2 * slpl_pkg::DEFAULT_SAMPLE_BITS,
    parameter int DEPTH = slpl_pkg::DEFAULT_DELAY_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word when both ports hit the same entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/slpl_div.sv]
module slpl_div #(
    parameter int WIDTH = slpl_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [WIDTH-1:0]          dividend,
    input  logic [WIDTH-1:0]          divisor,
    output logic [WIDTH-2:0]          quotient,
    output slpl_pkg::div_status_t     status
);

    // fractional quotient dividend * 2^(WIDTH-1) / divisor, needs dividend < divisor
    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] div_reg, div_next;
    logic [WIDTH-2:0] q_reg, q_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   sh;
    logic             ge;

    always_comb begin
        sh        = {rem_reg, 1'b0};
        ge        = sh >= {1'b0, div_reg};
        rem_next  = rem_reg;
        div_next  = div_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            div_next  = divisor;
            cnt_next  = CW'(WIDTH - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? WIDTH'(sh - {1'b0, div_reg}) : sh[WIDTH-1:0];
            q_next   = {q_reg[WIDTH-3:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg   <= q_next;
    end

    assign quotient    = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[rtl/stereo_lookahead_peak_limiter_core.sv]
// Stereo lookahead peak limiter.
// Input stream: s_tdata carries one stereo pair per transaction, s_tlast marks
// the last pair of a metering block. Output stream: m_tdata carries the delayed,
// limited pair and the block meters, m_tlast says the meters cover a full block.
// The config port writes one register per cycle; the user must write it only
// while the core is idle, as the core itself does not enforce this. Each pair
// takes one pass of a sequencer around the delay line memory: the write and
// the delayed read go to the memory at acceptance, the read word comes back
// in the next cycle. When the input peak exceeds the ceiling, a restoring
// divider forms the target gain, one quotient bit a cycle. One shared product
// register then holds the envelope step and both gain products in turn.
// A finished result sits in the output register, so the next pair is accepted
// while m_tready is low; a second result waits in the sequencer until the
// output register frees up, and s_tready stays low meanwhile.
// Reset restores the register defaults, unity gain and cleared meters; the
// delay line reads as zero until each entry has been written once, so no
// clearing pass is needed.
`include "stereo_lookahead_peak_limiter_core_assert.svh"

module stereo_lookahead_peak_limiter_core #(
    parameter int DELAY_DEPTH = slpl_pkg::DEFAULT_DELAY_DEPTH,
    parameter int SAMPLE_BITS = slpl_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // in_left, in_right
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
    input  logic                                s_tlast,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // out_left, out_right, peak_level, max_reduction
    output logic [((2*SAMPLE_BITS+2*slpl_pkg::METER_W+7)/8)*8-1:0] m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [slpl_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [slpl_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int XW  = ((SB > slpl_pkg::CEIL_W) ? SB : slpl_pkg::CEIL_W) + 1;
    localparam int MW  = SB + ((SB > slpl_pkg::COEF_W) ? SB : slpl_pkg::COEF_W);
    localparam int MDW = ((2*SB+2*slpl_pkg::METER_W+7)/8)*8;
    localparam int LAN = 2 ** slpl_pkg::LA_W;
    localparam logic [SB-1:0] UNITY    = {1'b1, {(SB-1){1'b0}}};
    localparam logic [AW-1:0] LAST_IDX = AW'(DELAY_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH, ST_DIVIDE, ST_STEP, ST_ENV,
        ST_MUL_L, ST_MUL_R, ST_CLAMP_R, ST_METER
    } state_t;

    function automatic logic [SB-1:0] mag(input logic [SB-1:0] v);
        mag = v[SB-1] ? SB'(-v) : v;
    endfunction

    function automatic logic [slpl_pkg::METER_W-1:0] meter(input logic [SB-1:0] v);
        logic [XW-1:0] t;
        t = XW'(v);
        meter = t[slpl_pkg::METER_W-1:0];
    endfunction

    function automatic logic [SB-1:0] scale_clamp(input logic [MW-1:0] prod,
                                                  input logic neg,
                                                  input logic [SB-1:0] ceil_v);
        logic [SB-1:0]      m;
        logic signed [SB:0] sv;
        logic signed [SB:0] hi;
        logic signed [SB:0] lo;
        m  = SB'(prod >> (SB - 1));
        sv = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        hi = (ceil_v < UNITY) ? $signed({1'b0, ceil_v}) : $signed({1'b0, UNITY - 1'b1});
        lo = -$signed({1'b0, ceil_v});
        if (sv > hi) begin
            sv = hi;
        end
        if (sv < lo) begin
            sv = lo;
        end
        scale_clamp = sv[SB-1:0];
    endfunction

    // configuration
    logic [slpl_pkg::CEIL_W-1:0] ceiling_reg;
    logic                        limiter_reg;
    logic [slpl_pkg::COEF_W-1:0] attack_reg;
    logic [slpl_pkg::COEF_W-1:0] release_reg;
    logic [slpl_pkg::LA_W-1:0]   la_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_reg <= slpl_pkg::CEILING_RST;
            limiter_reg <= 1'b1;
            attack_reg  <= slpl_pkg::ATTACK_RST;
            release_reg <= slpl_pkg::RELEASE_RST;
            la_reg      <= slpl_pkg::LOOKAHEAD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                slpl_pkg::REG_CEILING:   ceiling_reg <= cfg_wdata[slpl_pkg::CEIL_W-1:0];
                slpl_pkg::REG_LIMITER:   limiter_reg <= cfg_wdata[0];
                slpl_pkg::REG_ATTACK:    attack_reg  <= cfg_wdata[slpl_pkg::COEF_W-1:0];
                slpl_pkg::REG_RELEASE:   release_reg <= cfg_wdata[slpl_pkg::COEF_W-1:0];
                slpl_pkg::REG_LOOKAHEAD: la_reg      <= cfg_wdata[slpl_pkg::LA_W-1:0];
                default: ;
            endcase
        end
    end

    // lookahead reduced modulo the depth
    logic [AW-1:0] la_mod_tab [LAN];
    for (genvar g = 0; g < LAN; g++) begin : g_la_mod
        assign la_mod_tab[g] = AW'(g % DELAY_DEPTH);
    end

    logic [XW-1:0] ceil_x;
    logic [SB-1:0] ceil_c;
    assign ceil_x = XW'(ceiling_reg);
    assign ceil_c = (ceil_x > XW'(UNITY)) ? UNITY : ceil_x[SB-1:0];

    // sequencer state
    state_t           state_reg, state_next;
    logic [AW-1:0]    w_reg, w_next;
    logic             wrapped_reg, wrapped_next;
    logic             rd_ok_reg, rd_ok_next;
    logic             last_reg, last_next;
    logic             need_div_reg, need_div_next;
    logic [SB-1:0]    dl_reg, dl_next;
    logic [SB-1:0]    dr_reg, dr_next;
    logic [SB-1:0]    target_reg, target_next;
    logic [SB-1:0]    env_reg, env_next;
    logic             fall_reg, fall_next;
    logic [MW-1:0]    mul_reg, mul_next;
    logic [SB-1:0]    peak_reg, peak_next;
    logic [SB-1:0]    red_reg, red_next;
    logic             m_valid_reg, m_valid_next;
    logic [MDW-1:0]   m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;

    logic                  s_accept;
    logic [SB-1:0]         in_l, in_r, det;
    logic [AW-1:0]         la_m, rd_addr;
    logic [AW:0]           rd_wide;
    logic [2*SB-1:0]       ram_q;
    logic                  div_start;
    logic [SB-2:0]         div_q;
    slpl_pkg::div_status_t div_stat;
    logic [SB-1:0]         diff, stepv, pk, peak_new, red_new;
    logic [slpl_pkg::COEF_W-1:0] coef;
    logic                  out_free;

    assign s_tready = state_reg == ST_IDLE;
    assign s_accept = s_tvalid && s_tready;
    assign in_l     = s_tdata[SB-1:0];
    assign in_r     = s_tdata[2*SB-1:SB];
    assign det      = (mag(in_l) > mag(in_r)) ? mag(in_l) : mag(in_r);

    assign la_m    = la_mod_tab[la_reg];
    assign rd_wide = {1'b0, w_reg} + (AW+1)'(DELAY_DEPTH) - {1'b0, la_m};
    assign rd_addr = (w_reg >= la_m) ? (w_reg - la_m) : rd_wide[AW-1:0];

    assign div_start = s_accept && limiter_reg && (det > ceil_c);
    assign out_free  = !m_valid_reg || m_tready;

    slpl_ram #(.WIDTH(2 * SB), .DEPTH(DELAY_DEPTH)) u_delay (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (w_reg),
        .wdata ({in_r, in_l}),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    slpl_div #(.WIDTH(SB)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (ceil_c),
        .divisor  (det),
        .quotient (div_q),
        .status   (div_stat)
    );

    always_comb begin
        state_next    = state_reg;
        w_next        = w_reg;
        wrapped_next  = wrapped_reg;
        rd_ok_next    = rd_ok_reg;
        last_next     = last_reg;
        need_div_next = need_div_reg;
        dl_next       = dl_reg;
        dr_next       = dr_reg;
        target_next   = target_reg;
        env_next      = env_reg;
        fall_next     = fall_reg;
        mul_next      = mul_reg;
        peak_next     = peak_reg;
        red_next      = red_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;

        diff  = (env_reg >= target_reg) ? (env_reg - target_reg) : (target_reg - env_reg);
        coef  = (target_reg < env_reg) ? attack_reg : release_reg;
        stepv = SB'(mul_reg >> slpl_pkg::COEF_W);
        pk    = (mag(dl_reg) > mag(dr_reg)) ? mag(dl_reg) : mag(dr_reg);
        peak_new = (pk > peak_reg) ? pk : peak_reg;
        red_new  = (limiter_reg && (SB'(UNITY - env_reg) > red_reg)) ?
                   SB'(UNITY - env_reg) : red_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    // entries not yet written since reset read as zero
                    rd_ok_next    = wrapped_reg || (rd_addr < w_reg);
                    last_next     = s_tlast;
                    need_div_next = det > ceil_c;
                    w_next        = (w_reg == LAST_IDX) ? '0 : w_reg + 1'b1;
                    if (w_reg == LAST_IDX) begin
                        wrapped_next = 1'b1;
                    end
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                dl_next = rd_ok_reg ? ram_q[SB-1:0] : '0;
                dr_next = rd_ok_reg ? ram_q[2*SB-1:SB] : '0;
                if (!limiter_reg) begin
                    state_next = ST_METER;
                end else if (need_div_reg) begin
                    state_next = ST_DIVIDE;
                end else begin
                    target_next = UNITY;
                    state_next  = ST_STEP;
                end
            end
            ST_DIVIDE: begin
                if (div_stat.done) begin
                    target_next = {1'b0, div_q};
                    state_next  = ST_STEP;
                end
            end
            ST_STEP: begin
                fall_next  = env_reg >= target_reg;
                mul_next   = MW'(coef) * MW'(diff);
                state_next = ST_ENV;
            end
            ST_ENV: begin
                // step truncated toward the target
                env_next   = fall_reg ? (target_reg + stepv) : (target_reg - stepv);
                state_next = ST_MUL_L;
            end
            ST_MUL_L: begin
                mul_next   = MW'(mag(dl_reg)) * MW'(env_reg);
                state_next = ST_MUL_R;
            end
            ST_MUL_R: begin
                dl_next    = scale_clamp(mul_reg, dl_reg[SB-1], ceil_c);
                mul_next   = MW'(mag(dr_reg)) * MW'(env_reg);
                state_next = ST_CLAMP_R;
            end
            ST_CLAMP_R: begin
                dr_next    = scale_clamp(mul_reg, dr_reg[SB-1], ceil_c);
                state_next = ST_METER;
            end
            ST_METER: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = MDW'({meter(red_new), meter(peak_new), dr_reg, dl_reg});
                    m_last_next  = last_reg;
                    peak_next    = last_reg ? '0 : peak_new;
                    red_next     = last_reg ? '0 : red_new;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            w_reg       <= '0;
            wrapped_reg <= 1'b0;
            env_reg     <= UNITY;
            peak_reg    <= '0;
            red_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            w_reg       <= w_next;
            wrapped_reg <= wrapped_next;
            env_reg     <= env_next;
            peak_reg    <= peak_next;
            red_reg     <= red_next;
            m_valid_reg <= m_valid_next;
        end
        rd_ok_reg    <= rd_ok_next;
        last_reg     <= last_next;
        need_div_reg <= need_div_next;
        dl_reg       <= dl_next;
        dr_reg       <= dr_next;
        target_reg   <= target_next;
        fall_reg     <= fall_next;
        mul_reg      <= mul_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `SLPL_ASSERT_NEXT(a_one_item, aclk, aresetn, s_accept, !s_tready, "second item taken while busy")
    `SLPL_ASSERT(a_div_done_state, aclk, aresetn, !div_stat.done || state_reg == ST_DIVIDE, "quotient arrived outside the divide step")
    `SLPL_ASSERT(a_div_busy_state, aclk, aresetn, !div_stat.busy || state_reg == ST_FETCH || state_reg == ST_DIVIDE, "divider busy outside the divide step")
    `SLPL_ASSERT(a_env_range, aclk, aresetn, env_reg <= UNITY, "gain envelope above unity")
    `SLPL_ASSERT_NEXT(a_result_source, aclk, aresetn, !m_valid_reg || m_tready, !m_valid_reg || $past(state_reg == ST_METER), "result loaded outside the meter step")

endmodule

[dv/tb_stereo_lookahead_peak_limiter_core.sv]
module tb_stereo_lookahead_peak_limiter_core;

    localparam longint UNITY = 64'd8388608;
    localparam int DEPTH = 256;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 8000;
    // indexes with no register behind them
    localparam logic [slpl_pkg::CFG_AW-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [slpl_pkg::CFG_AW-1:0] REG_SPARE_HI = 3'd7;
    localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] S_MIN = 24'sh800000;

    logic        aclk;
    logic        aresetn = 1'b0;
    // in_left, in_right
    logic [47:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // out_left, out_right, peak_level, max_reduction
    logic [95:0] m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [slpl_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [slpl_pkg::CFG_W-1:0]  cfg_wdata = '0;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold = 0;

    typedef struct {
        logic [23:0] left;
        logic [23:0] right;
        logic [23:0] peak;
        logic [23:0] reduction;
        logic        done;
    } frame_t;

    class limiter_scoreboard;
        longint      dly_left[DEPTH];
        longint      dly_right[DEPTH];
        int unsigned wr_ptr;
        longint      envelope;
        longint      peak_acc;
        longint      reduction_acc;
        longint      ceiling;
        longint      atk_coef;
        longint      rel_coef;
        bit          enabled;
        int unsigned lookahead;
        frame_t      expected_frames[$];
        int          errors;

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                dly_left[i] = 0;
                dly_right[i] = 0;
            end
            wr_ptr = 0;
            envelope = UNITY;
            peak_acc = 0;
            reduction_acc = 0;
            ceiling = slpl_pkg::CEILING_RST;
            enabled = 1'b1;
            atk_coef = slpl_pkg::ATTACK_RST;
            rel_coef = slpl_pkg::RELEASE_RST;
            lookahead = slpl_pkg::LOOKAHEAD_RST;
            errors = 0;
        endfunction

        function void write_reg(logic [slpl_pkg::CFG_AW-1:0] addr,
                                logic [slpl_pkg::CFG_W-1:0] value);
            case (addr)
                slpl_pkg::REG_CEILING:   ceiling = value;
                slpl_pkg::REG_LIMITER:   enabled = value[0];
                slpl_pkg::REG_ATTACK:    atk_coef = value[slpl_pkg::COEF_W-1:0];
                slpl_pkg::REG_RELEASE:   rel_coef = value[slpl_pkg::COEF_W-1:0];
                slpl_pkg::REG_LOOKAHEAD: lookahead = value[slpl_pkg::LA_W-1:0];
                default: ;
            endcase
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // truncation toward zero
        function longint apply_gain(longint x);
            longint m;
            m = (mag(x) * envelope) / UNITY;
            return (x < 0) ? -m : m;
        endfunction

        function void note_pair(logic signed [23:0] l, logic signed [23:0] r, logic last);
            longint      in_l, in_r, ceil, detect, dl, dr, target, coef, stepv, hi, lo, pk;
            int unsigned rd;
            frame_t      f;
            in_l = l;
            in_r = r;
            ceil = (ceiling > UNITY) ? UNITY : ceiling;
            detect = (mag(in_l) > mag(in_r)) ? mag(in_l) : mag(in_r);
            rd = (wr_ptr + DEPTH - (lookahead % DEPTH)) % DEPTH;
            dl = dly_left[rd];
            dr = dly_right[rd];
            dly_left[wr_ptr] = in_l;
            dly_right[wr_ptr] = in_r;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            if (enabled) begin
                target = UNITY;
                if (detect > ceil)
                    target = (ceil * UNITY) / detect;
                coef = (target < envelope) ? atk_coef : rel_coef;
                // step is truncated toward the target
                if (envelope >= target) begin
                    stepv = (coef * (envelope - target)) >> 23;
                    envelope = target + stepv;
                end else begin
                    stepv = (coef * (target - envelope)) >> 23;
                    envelope = target - stepv;
                end
                hi = (ceil < UNITY) ? ceil : UNITY - 1;
                lo = -ceil;
                dl = apply_gain(dl);
                dr = apply_gain(dr);
                if (dl > hi) dl = hi;
                if (dl < lo) dl = lo;
                if (dr > hi) dr = hi;
                if (dr < lo) dr = lo;
                if (UNITY - envelope > reduction_acc)
                    reduction_acc = UNITY - envelope;
            end
            pk = (mag(dl) > mag(dr)) ? mag(dl) : mag(dr);
            if (pk > peak_acc)
                peak_acc = pk;
            f.left = dl[23:0];
            f.right = dr[23:0];
            f.peak = peak_acc[23:0];
            f.reduction = reduction_acc[23:0];
            f.done = last;
            expected_frames.push_back(f);
            if (last) begin
                peak_acc = 0;
                reduction_acc = 0;
            end
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("mismatch: %s got 0x%0h want 0x%0h", what, got, want);
        endtask

        task check_frame(logic [95:0] data, logic last);
            frame_t want;
            if (expected_frames.size() == 0) begin
                report("output transaction with nothing expected", data[23:0], 0);
                return;
            end
            want = expected_frames.pop_front();
            if (data[23:0] !== want.left)
                report("out_left", data[23:0], want.left);
            if (data[47:24] !== want.right)
                report("out_right", data[47:24], want.right);
            if (data[71:48] !== want.peak)
                report("peak_level", data[71:48], want.peak);
            if (data[95:72] !== want.reduction)
                report("max_reduction", data[95:72], want.reduction);
            if (last !== want.done)
                report("block_done", last, want.done);
        endtask

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    limiter_scoreboard sb = new();

    stereo_lookahead_peak_limiter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: check, then decide readiness for the next edge
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_frame(m_tdata, m_tlast);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic cfg_write(input logic [slpl_pkg::CFG_AW-1:0] addr,
                             input logic [slpl_pkg::CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(addr, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering, drain every expected frame, then let the sequencer go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_pair(input logic signed [23:0] l, input logic signed [23:0] r,
                             input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r, l};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_pair(l, r, last);
    endtask

    function automatic logic signed [23:0] rand_sample(int kind);
        longint m;
        case (kind)
            4, 5: begin
                m = $urandom_range(8388607, 6000000);
                return ($urandom_range(1) != 0) ? 24'(m) : 24'(-m);
            end
            6, 7: begin
                m = $urandom_range(800000, 0);
                return ($urandom_range(1) != 0) ? 24'(m) : 24'(-m);
            end
            8: begin
                case ($urandom_range(3))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return 24'sd0;
                    default: return -24'sd1;
                endcase
            end
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic run_random(input int n);
        int kind;
        logic signed [23:0] l, r;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(9);
            l = rand_sample(kind);
            r = (kind == 9) ? l : rand_sample(kind);
            send_pair(l, r, $urandom_range(15) == 0);
        end
    endtask

    task automatic set_pace(input int idle_pct, input int stall_pct);
        tx_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: short delay so each pair comes out with the next one
        cfg_write(slpl_pkg::REG_LOOKAHEAD, 1);
        cfg_write(slpl_pkg::REG_CEILING, 4194304);
        send_pair(0, 0, 1'b0);
        send_pair(S_MAX, S_MIN, 1'b0);
        send_pair(S_MIN, S_MAX, 1'b1);
        send_pair(1, -1, 1'b0);
        send_pair(-1, 1, 1'b0);
        send_pair(4194304, 0, 1'b0);
        send_pair(0, -4194305, 1'b0);
        send_pair(0, 0, 1'b1);
        settle();
        // bypass: envelope holds, peak still tracks
        cfg_write(slpl_pkg::REG_LIMITER, 0);
        send_pair(S_MAX, S_MIN, 1'b0);
        send_pair(123, -456, 1'b0);
        send_pair(S_MIN, S_MIN, 1'b1);
        settle();
        cfg_write(slpl_pkg::REG_LIMITER, 1);
        cfg_write(REG_SPARE_LO, '0);
        cfg_write(REG_SPARE_HI, '1);
        cfg_write(slpl_pkg::REG_CEILING, 0);
        send_pair(0, 0, 1'b0);
        send_pair(1000, -1000, 1'b0);
        send_pair(S_MAX, S_MIN, 1'b1);
        settle();
        // ceiling beyond unity acts as unity
        cfg_write(slpl_pkg::REG_CEILING, 24'hFFFFFF);
        send_pair(S_MAX, S_MIN, 1'b0);
        send_pair(S_MIN, S_MIN, 1'b1);
        send_pair(0, 0, 1'b0);
        settle();

        cfg_write(slpl_pkg::REG_CEILING, 529280);
        cfg_write(slpl_pkg::REG_ATTACK, 0);
        cfg_write(slpl_pkg::REG_RELEASE, 0);
        cfg_write(slpl_pkg::REG_LOOKAHEAD, 3);
        set_pace(0, 0);
        run_random(40);
        // receiver holds off while the sender keeps pushing
        rx_hold = HOLD_OFF_CYCLES;
        run_random(30);
        run_random(30);
        settle();

        cfg_write(slpl_pkg::REG_CEILING, 8388608);
        cfg_write(slpl_pkg::REG_ATTACK, 8388607);
        cfg_write(slpl_pkg::REG_RELEASE, 8388607);
        cfg_write(slpl_pkg::REG_LOOKAHEAD, 255);
        set_pace(84, 0);
        run_random(100);
        settle();

        // zero lookahead delays by the full line depth
        cfg_write(slpl_pkg::REG_CEILING, 24'hFFFFFF);
        cfg_write(slpl_pkg::REG_ATTACK, slpl_pkg::ATTACK_RST);
        cfg_write(slpl_pkg::REG_RELEASE, slpl_pkg::RELEASE_RST);
        cfg_write(slpl_pkg::REG_LOOKAHEAD, 0);
        set_pace(0, 84);
        run_random(100);
        settle();

        cfg_write(slpl_pkg::REG_LIMITER, 0);
        cfg_write(slpl_pkg::REG_CEILING, 2000000);
        cfg_write(slpl_pkg::REG_LOOKAHEAD, 17);
        set_pace(12, 12);
        run_random(50);
        settle();
        run_random(50);
        settle();

        cfg_write(slpl_pkg::REG_LIMITER, 1);
        cfg_write(slpl_pkg::REG_CEILING, 0);
        cfg_write(slpl_pkg::REG_LOOKAHEAD, 1);
        cfg_write(slpl_pkg::REG_ATTACK, 4000000);
        cfg_write(slpl_pkg::REG_RELEASE, 8000000);
        run_random(50);
        settle();

        cfg_write(slpl_pkg::REG_CEILING, $urandom_range(8388608, 529280));
        cfg_write(slpl_pkg::REG_ATTACK, $urandom_range(8388607, 0));
        cfg_write(slpl_pkg::REG_RELEASE, $urandom_range(8388607, 0));
        cfg_write(slpl_pkg::REG_LOOKAHEAD, $urandom_range(255, 1));
        set_pace(0, 0);
        run_random(125);
        settle();

        if (sb.pending() > 0)
            sb.report("frames never delivered", sb.pending(), 0);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/slpl_pkg.sv
rtl/slpl_ram.sv
rtl/slpl_div.sv
rtl/stereo_lookahead_peak_limiter_core.sv
dv/tb_stereo_lookahead_peak_limiter_core.sv
